/* rtl/iplpr_pkg.sv */
// shared types, constants and helpers for the ipv4 longest prefix router
// used by ipv4_longest_prefix_router_unit; no dependencies
package iplpr_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_PORTS = 8;
    localparam int PORT_W = 3;
    localparam int ADDR_W = 32;
    localparam int LEN_W = 6;
    localparam int TTL_W = 8;
    localparam int STATUS_W = 2;

    // input tdata layout, lowest bit first
    localparam int IN_PREFIX_LSB = 0;
    localparam int IN_LEN_LSB = IN_PREFIX_LSB + ADDR_W;
    localparam int IN_HAS_HOP_LSB = IN_LEN_LSB + LEN_W;
    localparam int IN_HOP_LSB = IN_HAS_HOP_LSB + 1;
    localparam int IN_PORT_LSB = IN_HOP_LSB + ADDR_W;
    localparam int IN_DEST_LSB = IN_PORT_LSB + PORT_W;
    localparam int IN_TTL_LSB = IN_DEST_LSB + ADDR_W;
    localparam int IN_USED_W = IN_TTL_LSB + TTL_W;
    localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout, lowest bit first
    localparam int OUT_USED_W = 1 + PORT_W + ADDR_W + TTL_W + STATUS_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    typedef enum logic {
        FUNC_ADD = 1'b0,
        FUNC_ROUTE = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK = 2'd0,
        ST_NO_ROUTE = 2'd1,
        ST_EXPIRED = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0] len;
        logic has_hop;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } entry_t;

    // keeps the top len bits of an address, len already clamped to 0..32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] mask;
        begin
            if (len == '0) begin
                mask = '0;
            end else if (len >= MAX_LEN) begin
                mask = '1;
            end else begin
                mask = ~({ADDR_W{1'b1}} >> len);
            end
            return mask;
        end
    endfunction

endpackage

/* rtl/ipv4_longest_prefix_router_unit.sv */
// ipv4 longest prefix match route table with stream input and result channels
// depends on iplpr_pkg; holds the route memory and the scan sequencer
//
// Add items append a route to a 64-entry table, then pass through the finish state to the
// output register. A full table drops the route and answers status 3. Route items scan the
// stored routes through the single registered read port of the table memory, one entry per
// cycle, and then finish the same way. Longest prefix wins, the earliest entry wins a tie,
// and length 0 matches any address. One item is in work at a time. The finished result
// sits in the output register, so a new item is taken while that result waits.
module ipv4_longest_prefix_router_unit (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // prefix, prefix_len, has_next_hop, hop_address, port_index,
    // dest_address, ttl_in
    input  logic [iplpr_pkg::IN_DATA_W-1:0] s_tdata,
    // func
    input  logic [0:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // forward, out_port, out_hop, ttl_out, status
    output logic [iplpr_pkg::OUT_DATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [iplpr_pkg::CNT_W-1:0] count_reg, count_next;
    logic [iplpr_pkg::CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic rd_valid_reg;
    logic m_tvalid_reg, m_tvalid_next;

    iplpr_pkg::func_t func_reg;
    iplpr_pkg::status_t add_status_reg;
    logic [iplpr_pkg::ADDR_W-1:0] dest_reg;
    logic [iplpr_pkg::TTL_W-1:0] ttl_reg;
    logic found_reg;
    logic [iplpr_pkg::LEN_W-1:0] best_len_reg;
    logic best_has_hop_reg;
    logic [iplpr_pkg::ADDR_W-1:0] best_hop_reg;
    logic [iplpr_pkg::PORT_W-1:0] best_port_reg;

    logic [iplpr_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    iplpr_pkg::entry_t mem [0:iplpr_pkg::TABLE_DEPTH-1];
    iplpr_pkg::entry_t rd_data_reg;
    iplpr_pkg::entry_t wr_entry;
    logic wr_en;
    logic rd_en;

    logic s_accept;
    logic out_load;
    logic add_ok;
    logic hit;
    logic take;
    logic [iplpr_pkg::LEN_W-1:0] in_len;
    logic [iplpr_pkg::PORT_W-1:0] in_port;

    logic res_forward;
    logic [iplpr_pkg::PORT_W-1:0] res_port;
    logic [iplpr_pkg::ADDR_W-1:0] res_hop;
    logic [iplpr_pkg::TTL_W-1:0] res_ttl;
    iplpr_pkg::status_t res_status;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    // input field decode
    assign in_len = s_tdata[iplpr_pkg::IN_LEN_LSB +: iplpr_pkg::LEN_W];
    assign in_port = s_tdata[iplpr_pkg::IN_PORT_LSB +: iplpr_pkg::PORT_W];
    assign add_ok = (count_reg < iplpr_pkg::CNT_W'(iplpr_pkg::TABLE_DEPTH))
                    && (32'(in_port) < iplpr_pkg::NUM_PORTS);

    always_comb begin
        wr_entry.prefix = s_tdata[iplpr_pkg::IN_PREFIX_LSB +: iplpr_pkg::ADDR_W];
        wr_entry.len = (in_len > iplpr_pkg::MAX_LEN) ? iplpr_pkg::MAX_LEN : in_len;
        wr_entry.has_hop = s_tdata[iplpr_pkg::IN_HAS_HOP_LSB];
        wr_entry.hop = s_tdata[iplpr_pkg::IN_HOP_LSB +: iplpr_pkg::ADDR_W];
        wr_entry.port = in_port;
    end

    // writes happen only on an add transfer in idle, never while a scan reads
    assign wr_en = s_accept && (iplpr_pkg::func_t'(s_tuser[0]) == iplpr_pkg::FUNC_ADD)
                   && add_ok;
    assign rd_en = (state_reg == S_SCAN) && (issue_idx_reg < count_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[iplpr_pkg::IDX_W-1:0]] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[issue_idx_reg[iplpr_pkg::IDX_W-1:0]];
        end
    end

    // compare stage on the entry read last cycle
    assign hit = ((rd_data_reg.prefix ^ dest_reg)
                  & iplpr_pkg::prefix_mask(rd_data_reg.len)) == '0;
    assign take = rd_valid_reg && hit && (!found_reg || (best_len_reg < rd_data_reg.len));

    assign out_load = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        issue_idx_next = issue_idx_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    issue_idx_next = '0;
                    if (iplpr_pkg::func_t'(s_tuser[0]) == iplpr_pkg::FUNC_ADD) begin
                        if (add_ok) begin
                            count_next = count_reg + 1'b1;
                        end
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end else if (!rd_valid_reg) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_idx_reg <= issue_idx_next;
            rd_valid_reg <= rd_en;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= iplpr_pkg::func_t'(s_tuser[0]);
            add_status_reg <= add_ok ? iplpr_pkg::ST_OK : iplpr_pkg::ST_FULL;
            dest_reg <= s_tdata[iplpr_pkg::IN_DEST_LSB +: iplpr_pkg::ADDR_W];
            ttl_reg <= s_tdata[iplpr_pkg::IN_TTL_LSB +: iplpr_pkg::TTL_W];
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
            best_len_reg <= rd_data_reg.len;
            best_has_hop_reg <= rd_data_reg.has_hop;
            best_hop_reg <= rd_data_reg.hop;
            best_port_reg <= rd_data_reg.port;
        end
        if (out_load) begin
            m_tdata_reg <= iplpr_pkg::OUT_DATA_W'({res_status, res_ttl, res_hop,
                                                  res_port, res_forward});
        end
    end

    always_comb begin
        res_forward = 1'b0;
        res_port = '0;
        res_hop = '0;
        res_ttl = '0;
        res_status = iplpr_pkg::ST_OK;
        if (func_reg == iplpr_pkg::FUNC_ADD) begin
            res_status = add_status_reg;
        end else if (!found_reg) begin
            res_status = iplpr_pkg::ST_NO_ROUTE;
            res_ttl = ttl_reg;
        end else begin
            res_ttl = (ttl_reg != '0) ? ttl_reg - 1'b1 : '0;
            if (ttl_reg > iplpr_pkg::TTL_W'(1)) begin
                res_forward = 1'b1;
                res_port = best_port_reg;
                res_hop = best_has_hop_reg ? best_hop_reg : dest_reg;
            end else begin
                res_status = iplpr_pkg::ST_EXPIRED;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= iplpr_pkg::CNT_W'(iplpr_pkg::TABLE_DEPTH))
        else $error("route count above table depth");

    a_count_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("table write did not advance the route count");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |=> $stable(count_reg))
        else $error("route count changed outside an add transfer");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !rd_valid_reg && !rd_en)
        else $error("table write overlaps a scan read");

    a_finish_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH) |-> !rd_valid_reg)
        else $error("result taken with a table read still in flight");

endmodule
